// File: rtl/trilinear_interpolator_top_assert.svh
// Assertion macros shared by the RTL.
// TLI_ASSERT_IMPL: when ante holds at a clock edge, cons holds at the same edge.
// TLI_ASSERT_NEXT: when ante holds at a clock edge, cons holds at the next edge.
`ifndef TRILINEAR_INTERPOLATOR_TOP_ASSERT_SVH
`define TRILINEAR_INTERPOLATOR_TOP_ASSERT_SVH

`define TLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tli assertion failed (same cycle)");

`define TLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tli assertion failed (next cycle)");

`endif

// File: rtl/tli_pkg.sv
package tli_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int FRAC_BITS   = 16;

  // stream packing
  localparam int IN_DATA_W  = ((4 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

  // internal widths
  localparam int FRAC_W   = FRAC_BITS + 1;
  localparam int DIFF_W   = VALUE_WIDTH + 1;
  localparam int NUM_W    = VALUE_WIDTH + 2;
  localparam int PROD_W   = DIFF_W + FRAC_W + 1;
  localparam int SUM_W    = PROD_W + 1;
  localparam int CNT_W    = $clog2(FRAC_BITS);
  localparam int AXIS_CNT = 3;
  localparam int AXIS_W   = 2;
  localparam int SLOT_W   = 3;
  localparam int LVL_W    = 2;
  localparam int PAIR_W   = 2;

  // item kinds and special slots
  localparam logic                OP_AXIS     = 1'b0;
  localparam logic                OP_CORNER   = 1'b1;
  localparam logic [SLOT_W-1:0]   LAST_CORNER = 3'd7;
  localparam logic [SLOT_W-1:0]   MAX_AXIS    = 3'd2;
  localparam logic [LVL_W-1:0]    LVL_Z       = 2'd0;
  localparam logic [LVL_W-1:0]    LVL_X       = 2'd2;
  localparam logic [PAIR_W-1:0]   PAIRS_Z_END = 2'd3;
  localparam logic [PAIR_W-1:0]   PAIRS_Y_END = 2'd1;
  localparam logic [FRAC_W-1:0]   FRAC_ONE    = FRAC_W'(1) << FRAC_BITS;

  typedef struct packed {
    logic              capture;   // input transfer this cycle
    logic              div_sub;   // form numerator and denominator
    logic              div_set;   // fold signs
    logic              div_chk;   // trivial cases, divider init
    logic              div_step;  // one quotient bit
    logic              div_last;  // final quotient bit, store fraction
    logic              rd_a;      // fetch lerp operand a
    logic              rd_b;      // fetch operand b, form difference
    logic              mul;       // difference times fraction
    logic              acc;       // round, add, store partial
    logic              out_load;  // load result register
    logic [LVL_W-1:0]  level;     // 0: z, 1: y, 2: x
    logic [PAIR_W-1:0] pair;
  } tli_cmd_t;

  typedef struct packed {
    logic              op;
    logic [SLOT_W-1:0] slot;
    logic              div_trivial;
  } tli_sts_t;

endpackage

// File: rtl/tli_dp.sv
module tli_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tli_pkg::tli_cmd_t                cmd,
  output tli_pkg::tli_sts_t                sts,
  input  logic [tli_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [tli_pkg::IN_USER_W-1:0]    in_tuser,
  input  logic                             in_tlast,
  output logic [tli_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                             out_tuser,
  output logic                             out_tlast
);

  localparam int VW = tli_pkg::VALUE_WIDTH;
  localparam int FB = tli_pkg::FRAC_BITS;
  localparam int HI_W = tli_pkg::SUM_W - FB;

  logic signed [VW-1:0] fld_q, fld_lo, fld_hi, fld_cv;

  logic signed [VW-1:0]                 q_r, lo_r, hi_r;
  logic [tli_pkg::AXIS_W-1:0]           slot_r;
  logic                                 last_r;
  logic signed [VW-1:0]                 corner_r [8];
  logic [tli_pkg::FRAC_W-1:0]           frac_r [tli_pkg::AXIS_CNT];
  logic                                 degen_r [tli_pkg::AXIS_CNT];
  logic signed [tli_pkg::DIFF_W-1:0]    num_r, den_r;
  logic signed [tli_pkg::NUM_W-1:0]     n_r;
  logic [tli_pkg::DIFF_W-1:0]           dv_r;
  logic [tli_pkg::NUM_W-1:0]            rem_r;
  logic [FB-1:0]                        quo_r;
  logic signed [VW-1:0]                 a_r;
  logic signed [tli_pkg::DIFF_W-1:0]    dd_r;
  logic signed [tli_pkg::PROD_W-1:0]    prod_r;
  logic signed [VW-1:0]                 scr_r [4];
  logic signed [VW-1:0]                 out_val_r;
  logic                                 out_degen_r;
  logic                                 out_last_r;

  logic                                 dv_zero, n_pos, n_ge;
  logic                                 div_trivial;
  logic [tli_pkg::FRAC_W-1:0]           triv_frac;
  logic [tli_pkg::NUM_W-1:0]            rem_sh, rem_nxt;
  logic                                 q_bit;
  logic [FB-1:0]                        quo_nxt;
  logic signed [VW-1:0]                 rd_val;
  logic [tli_pkg::FRAC_W-1:0]           f_sel;
  logic signed [tli_pkg::SUM_W-1:0]     sum;
  logic signed [HI_W-1:0]               hi_part;
  logic [HI_W-VW:0]                     hi_top;
  logic signed [VW-1:0]                 lerp_val;

  assign fld_q  = in_tdata[VW-1:0];
  assign fld_lo = in_tdata[2*VW-1:VW];
  assign fld_hi = in_tdata[3*VW-1:2*VW];
  assign fld_cv = in_tdata[4*VW-1:3*VW];

  assign sts.op          = in_tuser[0];
  assign sts.slot        = in_tuser[tli_pkg::SLOT_W:1];
  assign sts.div_trivial = div_trivial;

  // divider checks on the sign-folded operands
  always_comb begin
    dv_zero   = (dv_r == '0);
    n_pos     = !n_r[tli_pkg::NUM_W-1] && (n_r != '0);
    n_ge      = $unsigned(n_r) >= tli_pkg::NUM_W'(dv_r);
    div_trivial = dv_zero || !n_pos || n_ge;
    triv_frac = (!dv_zero && n_pos && n_ge) ? tli_pkg::FRAC_ONE : '0;
    rem_sh    = {rem_r[tli_pkg::NUM_W-2:0], 1'b0};
    q_bit     = rem_sh >= tli_pkg::NUM_W'(dv_r);
    rem_nxt   = q_bit ? rem_sh - tli_pkg::NUM_W'(dv_r) : rem_sh;
    quo_nxt   = {quo_r[FB-2:0], q_bit};
  end

  // lerp operand fetch and rounding add
  always_comb begin
    if (cmd.level == tli_pkg::LVL_Z) begin
      rd_val = corner_r[{cmd.pair, cmd.rd_b}];
    end else begin
      rd_val = scr_r[{cmd.pair[0], cmd.rd_b}];
    end
    f_sel   = frac_r[tli_pkg::AXIS_W'(tli_pkg::AXIS_CNT - 1) - cmd.level];
    // a * 2^FB plus the rounding half, then the product, in one add
    sum     = tli_pkg::SUM_W'($signed({a_r, 1'b1, {(FB-1){1'b0}}}))
            + tli_pkg::SUM_W'(prod_r);
    hi_part = sum[tli_pkg::SUM_W-1:FB];
    hi_top  = hi_part[HI_W-1:VW-1];
    if ((&hi_top) || !(|hi_top)) begin
      lerp_val = hi_part[VW-1:0];
    end else if (hi_part[HI_W-1]) begin
      lerp_val = {1'b1, {(VW-1){1'b0}}};
    end else begin
      lerp_val = {1'b0, {(VW-1){1'b1}}};
    end
  end

  // stored fractions and flags, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < tli_pkg::AXIS_CNT; i++) begin
        frac_r[i]  <= '0;
        degen_r[i] <= 1'b0;
      end
    end else if (cmd.div_chk && div_trivial) begin
      frac_r[slot_r]  <= triv_frac;
      degen_r[slot_r] <= dv_zero;
    end else if (cmd.div_step && cmd.div_last) begin
      frac_r[slot_r]  <= {1'b0, quo_nxt};
      degen_r[slot_r] <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      q_r    <= fld_q;
      lo_r   <= fld_lo;
      hi_r   <= fld_hi;
      slot_r <= sts.slot[tli_pkg::AXIS_W-1:0];
      last_r <= in_tlast;
      if (sts.op == tli_pkg::OP_CORNER) begin
        corner_r[sts.slot] <= fld_cv;
      end
    end
    if (cmd.div_sub) begin
      num_r <= tli_pkg::DIFF_W'(q_r) - tli_pkg::DIFF_W'(lo_r);
      den_r <= tli_pkg::DIFF_W'(hi_r) - tli_pkg::DIFF_W'(lo_r);
    end
    if (cmd.div_set) begin
      if (den_r[tli_pkg::DIFF_W-1]) begin
        n_r  <= -tli_pkg::NUM_W'(num_r);
        dv_r <= $unsigned(-den_r);
      end else begin
        n_r  <= tli_pkg::NUM_W'(num_r);
        dv_r <= $unsigned(den_r);
      end
    end
    if (cmd.div_chk) begin
      rem_r <= $unsigned(n_r);
      quo_r <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
    if (cmd.rd_a) begin
      a_r <= rd_val;
    end
    if (cmd.rd_b) begin
      dd_r <= tli_pkg::DIFF_W'(rd_val) - tli_pkg::DIFF_W'(a_r);
    end
    if (cmd.mul) begin
      prod_r <= tli_pkg::PROD_W'(dd_r) * tli_pkg::PROD_W'($signed({1'b0, f_sel}));
    end
    if (cmd.acc) begin
      scr_r[cmd.pair] <= lerp_val;
    end
    if (cmd.out_load) begin
      out_val_r   <= scr_r[0];
      out_degen_r <= degen_r[0] | degen_r[1] | degen_r[2];
      out_last_r  <= last_r;
    end
  end

  assign out_tdata = tli_pkg::OUT_DATA_W'($unsigned(out_val_r));
  assign out_tuser = out_degen_r;
  assign out_tlast = out_last_r;

endmodule

// File: rtl/tli_ctrl.sv
`include "trilinear_interpolator_top_assert.svh"

module tli_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  tli_pkg::tli_sts_t sts,
  output tli_pkg::tli_cmd_t cmd
);

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_DSUB = 10'b0000000010,
    S_DSET = 10'b0000000100,
    S_DCHK = 10'b0000001000,
    S_DIV  = 10'b0000010000,
    S_RDA  = 10'b0000100000,
    S_RDB  = 10'b0001000000,
    S_MUL  = 10'b0010000000,
    S_ACC  = 10'b0100000000,
    S_OUT  = 10'b1000000000
  } state_t;

  state_t                         state_r, state_nxt;
  logic [tli_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [tli_pkg::LVL_W-1:0]      level_r, level_nxt;
  logic [tli_pkg::PAIR_W-1:0]     pair_r, pair_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic                           accept;
  logic                           out_free;
  logic [tli_pkg::PAIR_W-1:0]     pair_end;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_free   = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign pair_end   = (level_r == tli_pkg::LVL_Z) ? tli_pkg::PAIRS_Z_END : tli_pkg::PAIRS_Y_END;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    level_nxt = level_r;
    pair_nxt  = pair_r;
    cmd          = '0;
    cmd.level    = level_r;
    cmd.pair     = pair_r;
    cmd.capture  = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (sts.op == tli_pkg::OP_AXIS && sts.slot <= tli_pkg::MAX_AXIS) begin
            state_nxt = S_DSUB;
          end else if (sts.op == tli_pkg::OP_CORNER && sts.slot == tli_pkg::LAST_CORNER) begin
            state_nxt = S_RDA;
            level_nxt = tli_pkg::LVL_Z;
            pair_nxt  = '0;
          end
        end
      end
      S_DSUB: begin
        cmd.div_sub = 1'b1;
        state_nxt   = S_DSET;
      end
      S_DSET: begin
        cmd.div_set = 1'b1;
        state_nxt   = S_DCHK;
      end
      S_DCHK: begin
        cmd.div_chk = 1'b1;
        cnt_nxt     = tli_pkg::CNT_W'(tli_pkg::FRAC_BITS - 1);
        state_nxt   = sts.div_trivial ? S_IDLE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == '0) begin
          cmd.div_last = 1'b1;
          state_nxt    = S_IDLE;
        end else begin
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      S_RDA: begin
        cmd.rd_a  = 1'b1;
        state_nxt = S_RDB;
      end
      S_RDB: begin
        cmd.rd_b  = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc = 1'b1;
        if (level_r == tli_pkg::LVL_X) begin
          state_nxt = S_OUT;
        end else if (pair_r == pair_end) begin
          level_nxt = level_r + 1'b1;
          pair_nxt  = '0;
          state_nxt = S_RDA;
        end else begin
          pair_nxt  = pair_r + 1'b1;
          state_nxt = S_RDA;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    out_valid_nxt = cmd.out_load || (out_valid_r && !out_tready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      level_r     <= '0;
      pair_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      level_r     <= level_nxt;
      pair_r      <= pair_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `TLI_ASSERT_IMPL(a_no_overwrite, clk, rst_n, cmd.out_load, !out_valid_r || out_tready)
  `TLI_ASSERT_NEXT(a_div_end, clk, rst_n, state_r == S_DIV && cnt_r == '0, state_r == S_IDLE)
  `TLI_ASSERT_NEXT(a_blend_end, clk, rst_n, state_r == S_ACC && level_r == tli_pkg::LVL_X, state_r == S_OUT)

endmodule

// File: rtl/trilinear_interpolator_top.sv
// Channel   Dir  tdata                               tuser                   tlast
// in_       in   query_coord, edge_low, edge_high,   opcode, slot_index      last_channel
//                corner_value
// out_      out  interp_value                        degenerate_box          last_of_point
//
// Axis item: subtract, sign-fold, check, then one quotient bit per cycle for
// FRAC_BITS bits; the check settles equal edges or a clamp; slot 3..7 starts nothing.
// Corner 0..6 item: stored. Corner 7 item: seven lerps on the one multiplier,
// then the output load; it waits while a result is held.
// Synchronous active-low reset clears control, the stored fractions and the
// degenerate flags; corners stay unknown until written.
module trilinear_interpolator_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // [31:0] query_coord, [63:32] edge_low, [95:64] edge_high, [127:96] corner_value
  input  logic [tli_pkg::IN_DATA_W-1:0]  in_tdata,
  // [0] opcode, [3:1] slot_index
  input  logic [tli_pkg::IN_USER_W-1:0]  in_tuser,
  input  logic                           in_tlast,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // [31:0] interp_value
  output logic [tli_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] degenerate_box
  output logic                           out_tuser,
  output logic                           out_tlast
);

  tli_pkg::tli_cmd_t cmd;   // controller to datapath
  tli_pkg::tli_sts_t sts;   // datapath to controller

  // sequencer: accepts a transfer only in idle, walks the divider and lerp steps
  tli_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // datapath: corner and fraction storage, divider, lerp unit, result register
  tli_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// File: tb/trilinear_interpolator_top_test.sv
module trilinear_interpolator_top_test;
  import tli_pkg::*;

  localparam int RANDOM_ITEMS = 800;
  localparam int N_DIRECTED   = 25;
  localparam int HOLD_CYCLES  = 400;  // long receiver hold-off, fills the block
  localparam int DRAIN_CYCLES = 64;   // extra wait once no result is pending
  localparam int PRINT_CAP    = 40;

  localparam logic [VALUE_WIDTH-1:0] VAL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
  localparam logic [VALUE_WIDTH-1:0] VAL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

  // one input transfer, unpacked from in_tdata / in_tuser / in_tlast
  typedef struct packed {
    logic                   op;
    logic [SLOT_W-1:0]      slot;
    logic [VALUE_WIDTH-1:0] coord;
    logic [VALUE_WIDTH-1:0] lo;
    logic [VALUE_WIDTH-1:0] hi;
    logic [VALUE_WIDTH-1:0] sample;
    logic                   last;
  } probe_item_t;

  // one output transfer
  typedef struct packed {
    logic [VALUE_WIDTH-1:0] value;
    logic                   flat;
    logic                   last;
  } blend_result_t;

  typedef struct packed {
    probe_item_t            item;
    logic                   known;        // result can be typed in directly
    logic [VALUE_WIDTH-1:0] known_value;
    logic                   known_flat;
  } directed_row_t;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic in_tvalid  = 1'b0;
  logic in_tlast   = 1'b0;
  logic out_tready = 1'b0;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [IN_USER_W-1:0] in_tuser = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  // predictor state: per-axis fractions, flat-cell flags, corners 0..6
  logic [FRAC_W-1:0]      frac_state [AXIS_CNT] = '{default: '0};
  logic [AXIS_CNT-1:0]    flat_axis = '0;
  logic [VALUE_WIDTH-1:0] corner_mem [7] = '{default: '0};

  blend_result_t pending_blends [$];
  int  mismatches = 0;
  int  taken      = 0;   // transfers that the block acts on
  int  burst_left = 0;
  bit  hold_req   = 1'b0;
  bit  hold_done  = 1'b0;

  // Directed rows. Corners go in first, so no blend ever reads an unwritten corner.
  // Fields: {op, slot, coord, lo, hi, sample, last}, known, value, flat
  directed_row_t directed_rows [N_DIRECTED] = '{
    '{'{OP_CORNER, 3'd0, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, 3'd1, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, 3'd2, 32'h0, 32'h0, 32'h0, 32'h0001_0000, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, 3'd3, 32'h0, 32'h0, 32'h0, 32'hFFFF_0000, 1'b1}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, 3'd4, 32'h0, 32'h0, 32'h0, 32'h0002_8000, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, 3'd5, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, 3'd6, 32'h0, 32'h0, 32'h0, 32'h0000_0001, 1'b0}, 1'b0, 32'h0, 1'b0},
    // fractions still zero from reset: result is corner 0
    '{'{OP_CORNER, LAST_CORNER, 32'h0, 32'h0, 32'h0, 32'h1234_5678, 1'b1},
      1'b1, 32'h8000_0000, 1'b0},
    // x = 1.0, y flat, z below the cell (clamped to 0)
    '{'{OP_AXIS, 3'd0, 32'h0001_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, 3'd1, 32'h0, 32'h0005_0000, 32'h0005_0000, 32'h0, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, 3'd2, 32'hFFFF_0000, 32'h0, 32'h0001_0000, 32'h0, 1'b0}, 1'b0, 32'h0, 1'b0},
    // x = 1, y = z = 0: corner 4, flat cell flagged
    '{'{OP_CORNER, LAST_CORNER, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, 32'h0002_8000, 1'b1},
    // axis slots out of range change nothing
    '{'{OP_AXIS, 3'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0},
      1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, LAST_CORNER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1},
      1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, LAST_CORNER, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b1},
      1'b1, 32'h0002_8000, 1'b1},
    // full-range edges: reversed cell near one half, then exactly 1.0
    '{'{OP_AXIS, 3'd1, 32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 1'b1}, 1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, 3'd2, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b0},
      1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, 3'd0, 32'h0001_0000, 32'h0, 32'h0003_0000, 32'h0, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, LAST_CORNER, 32'h0, 32'h0, 32'h0, 32'h8000_0000, 1'b1}, 1'b0, 32'h0, 1'b0},
    // zero numerator, numerator and span of opposite sign, negative span overrun
    '{'{OP_AXIS, 3'd0, 32'h0002_0000, 32'h0002_0000, 32'h0007_0000, 32'h0, 1'b0},
      1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, 3'd1, 32'h0005_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b0},
      1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, 3'd2, 32'hFFF0_0000, 32'h0, 32'hFFFF_0000, 32'h0, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, 3'd3, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_CORNER, LAST_CORNER, 32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 1'b0}, 1'b0, 32'h0, 1'b0},
    '{'{OP_AXIS, 3'd0, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1}, 1'b0, 32'h0, 1'b0}
  };

  trilinear_interpolator_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Restoring divide of (coord - lo) by (hi - lo), clamped to 0..1.0
  function automatic logic [FRAC_W-1:0] axis_fraction_of(longint num, longint den);
    longint            rem;
    logic [FRAC_W-1:0] quo;
    quo = '0;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    if (num <= 0) return '0;
    if (num >= den) return FRAC_ONE;
    rem = num;
    for (int i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= den) begin
        rem = rem - den;
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  // a + round(f * (b - a)), ties upward; the difference is split into
  // a high part (exact multiple) and a low part that carries the rounding
  function automatic longint lerp_step(longint a, longint b, logic [FRAC_W-1:0] f);
    longint d, dl, dh, fr, part;
    d    = b - a;
    dl   = d & ((longint'(1) << FRAC_BITS) - 1);
    dh   = (d - dl) >>> FRAC_BITS;
    fr   = longint'(f);
    part = dl * fr + (longint'(1) << (FRAC_BITS - 1));
    return a + dh * fr + (part >>> FRAC_BITS);
  endfunction

  // Updates the predictor with one accepted transfer; returns 1 with the
  // expected output when the transfer is the last corner.
  function automatic bit interpolate_item(input probe_item_t it, output blend_result_t res);
    longint c [8];
    longint e0, e1, e2, e3, g0, g1, v, vmax;
    res = '0;
    if (it.op == OP_AXIS) begin
      if (it.slot > MAX_AXIS) return 1'b0;
      if (it.hi == it.lo) begin
        frac_state[it.slot] = '0;
        flat_axis[it.slot]  = 1'b1;
      end else begin
        frac_state[it.slot] = axis_fraction_of(
          longint'($signed(it.coord)) - longint'($signed(it.lo)),
          longint'($signed(it.hi)) - longint'($signed(it.lo)));
        flat_axis[it.slot] = 1'b0;
      end
      return 1'b0;
    end
    if (it.slot != LAST_CORNER) begin
      corner_mem[it.slot] = it.sample;
      return 1'b0;
    end
    for (int i = 0; i < 7; i++) c[i] = longint'($signed(corner_mem[i]));
    c[7] = longint'($signed(it.sample));
    // z first (index bit 0), then y, then x
    e0 = lerp_step(c[0], c[1], frac_state[2]);
    e1 = lerp_step(c[2], c[3], frac_state[2]);
    e2 = lerp_step(c[4], c[5], frac_state[2]);
    e3 = lerp_step(c[6], c[7], frac_state[2]);
    g0 = lerp_step(e0, e1, frac_state[1]);
    g1 = lerp_step(e2, e3, frac_state[1]);
    v  = lerp_step(g0, g1, frac_state[0]);
    vmax = (longint'(1) << (VALUE_WIDTH - 1)) - 1;
    if (v > vmax) v = vmax;
    if (v < -vmax - 1) v = -vmax - 1;
    res.value = VALUE_WIDTH'(v);
    res.flat  = |flat_axis;
    res.last  = it.last;
    return 1'b1;
  endfunction

  function automatic probe_item_t random_item();
    probe_item_t it;
    it.op     = 1'($urandom);
    it.slot   = SLOT_W'($urandom);
    it.coord  = $urandom;
    it.lo     = $urandom;
    it.hi     = $urandom;
    it.sample = $urandom;
    it.last   = 1'($urandom);
    return it;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Offer one item until the transfer, record its prediction, then pace the
  // sender: random-length bursts with random gaps, no gaps during the hold-off.
  task automatic offer(input probe_item_t it, input bit known, input blend_result_t known_res);
    blend_result_t got;
    int            gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {it.sample, it.hi, it.lo, it.coord};
    in_tuser  <= {it.slot, it.op};
    in_tlast  <= it.last;
    do @(posedge clk); while (!in_tready);
    if (interpolate_item(it, got)) pending_blends.push_back(known ? known_res : got);
    if (!(it.op == OP_AXIS && it.slot > MAX_AXIS)) taken++;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 24);
    gap = ((hold_req && !hold_done) || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Result side: compare each output transfer with the oldest prediction.
  always @(posedge clk) begin : result_check
    blend_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_blends.size() == 0) begin
        flag_mismatch($sformatf("result %h with nothing pending", out_tdata));
      end else begin
        want = pending_blends.pop_front();
        if (out_tdata[VALUE_WIDTH-1:0] !== want.value)
          flag_mismatch($sformatf("interp_value %h, want %h", out_tdata, want.value));
        if (out_tuser !== want.flat)
          flag_mismatch($sformatf("degenerate_box %b, want %b", out_tuser, want.flat));
        if (out_tlast !== want.last)
          flag_mismatch($sformatf("last_of_point %b, want %b", out_tlast, want.last));
      end
    end
  end

  // Receiver: stretches of always-ready, coin-flip, mostly stalled and mostly
  // ready; once, a long hold-off while the sender keeps pushing.
  initial begin : rx_pattern
    int mode;
    int span;
    forever begin
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 64);
      repeat (span) begin
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= 1'($urandom);
          2:       out_tready <= ($urandom_range(0, 3) == 0);
          default: out_tready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : stimulus
    probe_item_t   it;
    blend_result_t want;
    int            span;
    int            offs;
    int            nch;
    bit            up;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_DIRECTED; r++) begin
      want.value = directed_rows[r].known_value;
      want.flat  = directed_rows[r].known_flat;
      want.last  = directed_rows[r].item.last;
      offer(directed_rows[r].item, directed_rows[r].known, want);
    end

    // Random part: mostly whole query points (three axes, then channels of
    // corners ending in the last corner), the rest arbitrary items.
    while (taken < N_DIRECTED + RANDOM_ITEMS) begin
      if (!hold_req && taken > N_DIRECTED + RANDOM_ITEMS / 3) hold_req = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        for (int a = 0; a < AXIS_CNT; a++) begin
          it      = random_item();
          it.op   = OP_AXIS;
          it.slot = SLOT_W'(a);
          span    = $urandom_range(1, 1 << 18);
          up      = 1'($urandom);
          it.lo   = $urandom_range(0, 1 << 21) - (1 << 20);
          it.hi   = up ? it.lo + span : it.lo - span;
          offs    = int'($urandom_range(0, span + span / 2)) - span / 4;
          it.coord = up ? it.lo + offs : it.lo - offs;
          case ($urandom_range(0, 9))
            0: it.hi = it.lo;
            1: it.coord = it.lo;
            2: it.coord = it.hi;
            3: begin
              it.coord = $urandom;
              it.lo    = $urandom;
              it.hi    = $urandom;
            end
            default: ;
          endcase
          offer(it, 1'b0, '0);
        end
        nch = $urandom_range(1, 3);
        for (int ch = 0; ch < nch; ch++) begin
          for (int k = 0; k <= LAST_CORNER; k++) begin
            // corners persist, so some are left from the previous channel
            if (k != LAST_CORNER && $urandom_range(0, 5) == 0) continue;
            it      = random_item();
            it.op   = OP_CORNER;
            it.slot = SLOT_W'(k);
            case ($urandom_range(0, 9))
              0:       it.sample = VAL_MIN;
              1:       it.sample = VAL_MAX;
              2, 3, 4: it.sample = $urandom_range(0, 1 << 21) - (1 << 20);
              default: ;
            endcase
            if (k == LAST_CORNER) it.last = (ch == nch - 1);
            offer(it, 1'b0, '0);
          end
        end
      end else begin
        offer(random_item(), 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    while (pending_blends.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("trilinear_interpolator_top test passed");
    end else begin
      $display("trilinear_interpolator_top test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin : watchdog
    #800000;
    $display("trilinear_interpolator_top test failed");
    $finish;
  end

endmodule
